// ===== hw/rtl/button_click_hold_classifier_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the button click/hold classifier
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_HOLD_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// cond must hold at every clock edge outside reset
`define BCHC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("bchc assertion failed");
// ante in one cycle implies cons in the next
`define BCHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bchc assertion failed");
`else
`define BCHC_ASSERT_ALWAYS(lbl, cond)
`define BCHC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/bchc_pkg.sv =====
// ---------------------------------------------------------------------------
// bchc_pkg
// Shared types and constants of the button click/hold classifier.
// ---------------------------------------------------------------------------
package bchc_pkg;

  localparam int STARTUP_TICKS = 1000;
  localparam int ELAPSED_W     = 17;
  localparam int THRESH_W      = 16;
  localparam int MAX_EVENTS    = 3;

  // event queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] REG_CLICK    = 2'd0;
  localparam logic [1:0] REG_HOLD_ONE = 2'd1;
  localparam logic [1:0] REG_HOLD_TWO = 2'd2;

  typedef enum logic [1:0] {
    KIND_CLICK    = 2'd0,
    KIND_HOLD_ONE = 2'd1,
    KIND_HOLD_TWO = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  released;
    logic  last;
  } event_t;

  typedef struct packed {
    logic [1:0]            cnt;
    event_t [MAX_EVENTS-1:0] ev;
  } bundle_t;

  typedef struct packed {
    logic [THRESH_W-1:0] click_ms;
    logic [THRESH_W-1:0] hold_one_ms;
    logic [THRESH_W-1:0] hold_two_ms;
  } thresh_t;

  typedef struct packed {
    logic              room;   // space for a full tick worth of events
    logic [QCNT_W-1:0] level;  // entries held
  } qstat_t;

endpackage

// ===== hw/rtl/bchc_core.sv =====
// ---------------------------------------------------------------------------
// bchc_core
// Press phase tracking, elapsed counter and per-tick event generation.
// ---------------------------------------------------------------------------
module bchc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              level,
  input  bchc_pkg::thresh_t thr,
  output bchc_pkg::bundle_t bundle
);

  typedef enum logic [1:0] {
    PH_STARTUP = 2'd0,
    PH_WAITREL = 2'd1,
    PH_IDLE    = 2'd2,
    PH_PRESSED = 2'd3
  } phase_t;

  localparam logic [bchc_pkg::ELAPSED_W-1:0] ELAPSED_MAX = '1;

  phase_t                           phase_r, phase_nxt;
  logic [bchc_pkg::ELAPSED_W-1:0]   elapsed_r, elapsed_nxt, elapsed_inc;
  logic [2:0]                       done_r, done_nxt;
  logic [2:0]                       fire;
  logic                             fire_rel;
  logic                             go_wait;
  logic [1:0]                       idx;

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    done_nxt    = done_r;
    fire        = '0;
    fire_rel    = 1'b0;
    go_wait     = 1'b0;
    elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
    unique case (phase_r)
      PH_STARTUP: begin
        if (elapsed_r < bchc_pkg::ELAPSED_W'(bchc_pkg::STARTUP_TICKS)) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end else begin
          go_wait = 1'b1;
        end
      end
      PH_WAITREL: go_wait = 1'b1;
      PH_IDLE: begin
        if (!level) begin
          phase_nxt   = PH_PRESSED;
          elapsed_nxt = '0;
          done_nxt    = '0;
        end
      end
      PH_PRESSED: begin
        if (!level) begin
          elapsed_nxt = elapsed_inc;
          fire[0] = (elapsed_inc > {1'b0, thr.click_ms})    && !done_r[0];
          fire[1] = (elapsed_inc > {1'b0, thr.hold_one_ms}) && !done_r[1];
          fire[2] = (elapsed_inc > {1'b0, thr.hold_two_ms}) && !done_r[2];
          done_nxt = done_r | fire;
        end else begin
          fire_rel  = done_r[0] && !done_r[1] && !done_r[2];
          phase_nxt = PH_IDLE;
        end
      end
    endcase
    if (go_wait) begin
      phase_nxt = level ? PH_IDLE : PH_WAITREL;
    end
  end

  // pack firing events in order click, hold one, hold two
  always_comb begin
    bundle = '0;
    idx    = '0;
    for (int k = 0; k < bchc_pkg::MAX_EVENTS; k++) begin
      if (fire[k]) begin
        bundle.ev[idx].kind     = bchc_pkg::kind_t'(2'(k));
        bundle.ev[idx].released = 1'b0;
        idx = idx + 1'b1;
      end
    end
    if (fire_rel) begin
      bundle.ev[0].kind     = bchc_pkg::KIND_CLICK;
      bundle.ev[0].released = 1'b1;
      idx = 2'd1;
    end
    if (idx != 2'd0) begin
      bundle.ev[idx - 1'b1].last = 1'b1;
    end
    bundle.cnt = idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_STARTUP;
      elapsed_r <= '0;
      done_r    <= '0;
    end else if (tick) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule

// ===== hw/rtl/bchc_evq.sv =====
// ---------------------------------------------------------------------------
// bchc_evq
// Event queue: takes up to three events per cycle, hands out one.
// ---------------------------------------------------------------------------
module bchc_evq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bchc_pkg::bundle_t bundle,
  input  logic              pop,
  output logic              not_empty,
  output bchc_pkg::event_t  head,
  output bchc_pkg::qstat_t  stat
);

  bchc_pkg::event_t                 q_r [bchc_pkg::QDEPTH];
  logic [bchc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [bchc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [bchc_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic [1:0]                       n_push;

  assign n_push     = push ? bundle.cnt : 2'd0;
  assign wr_ptr_nxt = wr_ptr_r + bchc_pkg::QPTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + bchc_pkg::QPTR_W'(pop);
  assign cnt_nxt    = cnt_r + bchc_pkg::QCNT_W'(n_push) - bchc_pkg::QCNT_W'(pop);

  assign not_empty  = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign stat.level = cnt_r;
  assign stat.room  = (cnt_r <= bchc_pkg::QCNT_W'(bchc_pkg::QDEPTH - bchc_pkg::MAX_EVENTS));

  always_ff @(posedge clk) begin
    for (int k = 0; k < bchc_pkg::MAX_EVENTS; k++) begin
      if (2'(k) < n_push) begin
        q_r[wr_ptr_r + bchc_pkg::QPTR_W'(k)] <= bundle.ev[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/button_click_hold_classifier.sv =====
// ---------------------------------------------------------------------------
// button_click_hold_classifier
// Classifies sampled button levels into click, hold one and hold two events.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_button_level
//  out     | output    | out_valid/out_stall| out_event_kind, out_event_released,
//          |           |                    | out_last_event
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// One tick per cycle; a tick is taken whenever the 8-entry event queue has
// room for three events; unstalled, events leave the queue head one per cycle.
// A tick's events are in the queue the cycle after its transfer.
// Synchronous reset restores thresholds and state at once; no clearing pass.
// Output stalls only back up the queue; ticks stall once it is nearly full.
// ---------------------------------------------------------------------------
`include "button_click_hold_classifier_assert.svh"

module button_click_hold_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_button_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic        out_event_released,
  output logic        out_last_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  bchc_pkg::thresh_t thr_r;
  bchc_pkg::bundle_t bundle;
  bchc_pkg::event_t  head;
  bchc_pkg::qstat_t  qstat;
  logic              tick;
  logic              pop;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = !qstat.room;
  assign tick      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.click_ms    <= 16'd50;
      thr_r.hold_one_ms <= 16'd1000;
      thr_r.hold_two_ms <= 16'd3000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bchc_pkg::REG_CLICK:    thr_r.click_ms    <= cfg_wdata;
        bchc_pkg::REG_HOLD_ONE: thr_r.hold_one_ms <= cfg_wdata;
        bchc_pkg::REG_HOLD_TWO: thr_r.hold_two_ms <= cfg_wdata;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  bchc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (tick),
    .level  (in_button_level),
    .thr    (thr_r),
    .bundle (bundle)
  );

  bchc_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick),
    .bundle    (bundle),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head),
    .stat      (qstat)
  );

  assign out_event_kind     = head.kind;
  assign out_event_released = head.released;
  assign out_last_event     = head.last;

  `BCHC_ASSERT_ALWAYS(a_q_bound, qstat.level <= bchc_pkg::QCNT_W'(bchc_pkg::QDEPTH))
  `BCHC_ASSERT_NEXT(a_evt_shows, tick && (bundle.cnt != 2'd0), out_valid)
  `BCHC_ASSERT_NEXT(a_cfg_click, cfg_we && (cfg_index == bchc_pkg::REG_CLICK), thr_r.click_ms == $past(cfg_wdata))
  `BCHC_ASSERT_ALWAYS(a_last_tail, !tick || (bundle.cnt == 2'd0) || bundle.ev[bundle.cnt - 2'd1].last)

endmodule

// ===== verif/bchc_checker.sv =====
// ---------------------------------------------------------------------------
// bchc_checker
// Watches the tick, event and register channels of the button click/hold
// classifier, predicts the events each accepted tick raises and compares
// every accepted event with the oldest prediction.
// ---------------------------------------------------------------------------
module bchc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_button_level,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_event_kind,
  input  logic        out_event_released,
  input  logic        out_last_event,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          events_owed
);

  typedef enum logic [1:0] {
    SC_BOOT,
    SC_WAIT_RELEASE,
    SC_IDLE,
    SC_HELD
  } scan_t;

  localparam logic [16:0] HELD_MAX = 17'h1FFFF;

  scan_t               scan;
  logic [16:0]         held_ms;
  logic                click_seen;
  logic                hold_one_seen;
  logic                hold_two_seen;
  logic [15:0]         click_lim;
  logic [15:0]         hold_one_lim;
  logic [15:0]         hold_two_lim;
  bchc_pkg::event_t    owed_q[$];
  bchc_pkg::event_t    want;
  int                  fails = 0;

  function automatic bchc_pkg::event_t make_event(input bchc_pkg::kind_t kind,
                                                  input logic released);
    bchc_pkg::event_t e;
    e.kind     = kind;
    e.released = released;
    e.last     = 1'b0;
    return e;
  endfunction

  // one millisecond tick; queues the events it raises, last one flagged
  task automatic predict_tick(input logic level);
    bchc_pkg::event_t evs [3];
    bchc_pkg::event_t e;
    int               n;
    logic             pressed;
    n       = 0;
    pressed = !level;
    if (scan == SC_BOOT && held_ms < bchc_pkg::STARTUP_TICKS) begin
      held_ms = held_ms + 1'b1;
    end else begin
      if (scan == SC_BOOT) scan = SC_WAIT_RELEASE;
      case (scan)
        SC_WAIT_RELEASE: begin
          if (!pressed) scan = SC_IDLE;
        end
        SC_IDLE: begin
          if (pressed) begin
            scan          = SC_HELD;
            held_ms       = '0;
            click_seen    = 1'b0;
            hold_one_seen = 1'b0;
            hold_two_seen = 1'b0;
          end
        end
        default: begin
          if (pressed) begin
            if (held_ms != HELD_MAX) held_ms = held_ms + 1'b1;
            // each threshold on its own, fixed order
            if (held_ms > click_lim && !click_seen) begin
              click_seen = 1'b1;
              evs[n]     = make_event(bchc_pkg::KIND_CLICK, 1'b0);
              n++;
            end
            if (held_ms > hold_one_lim && !hold_one_seen) begin
              hold_one_seen = 1'b1;
              evs[n]        = make_event(bchc_pkg::KIND_HOLD_ONE, 1'b0);
              n++;
            end
            if (held_ms > hold_two_lim && !hold_two_seen) begin
              hold_two_seen = 1'b1;
              evs[n]        = make_event(bchc_pkg::KIND_HOLD_TWO, 1'b0);
              n++;
            end
          end else begin
            if (click_seen && !hold_one_seen && !hold_two_seen) begin
              evs[n] = make_event(bchc_pkg::KIND_CLICK, 1'b1);
              n++;
            end
            scan = SC_IDLE;
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      e      = evs[i];
      e.last = (i == n - 1);
      owed_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      click_lim     = 16'd50;
      hold_one_lim  = 16'd1000;
      hold_two_lim  = 16'd3000;
      scan          = SC_BOOT;
      held_ms       = '0;
      click_seen    = 1'b0;
      hold_one_seen = 1'b0;
      hold_two_seen = 1'b0;
      owed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bchc_pkg::REG_CLICK:    click_lim    = cfg_wdata;
          bchc_pkg::REG_HOLD_ONE: hold_one_lim = cfg_wdata;
          bchc_pkg::REG_HOLD_TWO: hold_two_lim = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_tick(in_button_level);
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $display("%0t: event with none expected: kind %0d released %0d last %0d",
                   $time, out_event_kind, out_event_released, out_last_event);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (out_event_kind !== want.kind) begin
            $display("%0t: event_kind expected %0d actual %0d",
                     $time, want.kind, out_event_kind);
            fails++;
          end
          if (out_event_released !== want.released) begin
            $display("%0t: event_released expected %0d actual %0d",
                     $time, want.released, out_event_released);
            fails++;
          end
          if (out_last_event !== want.last) begin
            $display("%0t: last_event expected %0d actual %0d",
                     $time, want.last, out_last_event);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    events_owed <= owed_q.size();
  end

endmodule

// ===== verif/button_click_hold_classifier_tb.sv =====
// ---------------------------------------------------------------------------
// button_click_hold_classifier_tb
// Drives button ticks and threshold writes into the classifier: startup,
// threshold boundaries, coinciding and reordered thresholds, a press at the
// top thresholds, then random press/release runs under several idle and
// stall mixes. The checker beside the block predicts and compares every event.
// ---------------------------------------------------------------------------
module button_click_hold_classifier_tb;

  localparam int         IDLE_LIMIT = 2000;
  localparam logic [1:0] REG_SPARE  = 2'd3;  // no register behind it

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic        in_button_level = 1'b1;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [1:0]  out_event_kind;
  logic        out_event_released;
  logic        out_last_event;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index       = '0;
  logic [15:0] cfg_wdata       = '0;
  int          fail_count;
  int          events_owed;

  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;

  always #5 clk = ~clk;

  button_click_hold_classifier dut (.*);

  bchc_checker checker_i (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_tick(input logic level);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_button_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_run(input logic level, input int count);
    repeat (count) send_tick(level);
  endtask

  // stop ticks until every predicted event is out and the last tick settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] click, input logic [15:0] hold_one,
                            input logic [15:0] hold_two, input bit spare);
    drain();
    write_reg(bchc_pkg::REG_CLICK, click);
    write_reg(bchc_pkg::REG_HOLD_ONE, hold_one);
    write_reg(bchc_pkg::REG_HOLD_TWO, hold_two);
    if (spare) write_reg(REG_SPARE, 16'($urandom_range(65535)));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_limit();
    if ($urandom_range(99) < 75) return 16'($urandom_range(24));
    return 16'($urandom_range(65535));
  endfunction

  // mostly press runs then release runs, with stray ticks mixed in
  task automatic run_phase(input int sender_idle, input int recv_stall,
                           input int items, input bit pause_mid);
    int  sent;
    int  len;
    bit  paused;
    sent   = 0;
    paused = 0;
    set_limits(pick_limit(), pick_limit(), pick_limit(), $urandom_range(1));
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    while (sent < items) begin
      if (pause_mid && !paused && sent >= items / 2) begin
        drain();
        paused = 1;
      end
      if ($urandom_range(99) < 15) begin
        send_tick(1'($urandom_range(1)));
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 28);
        send_run(1'b0, len);
        sent += len;
        len = $urandom_range(1, 3);
        send_run(1'b1, len);
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // startup delay ignores the samples; held button then waits for release
    send_run(1'b0, 1);
    repeat (bchc_pkg::STARTUP_TICKS - 1) send_tick(1'($urandom_range(1)));
    send_run(1'b0, 5);
    send_tick(1'b1);

    // reset thresholds: just below and at click
    send_run(1'b0, 1);
    send_tick(1'b1);
    send_run(1'b0, 51);
    send_tick(1'b1);
    send_run(1'b0, 52);
    send_tick(1'b1);

    // all zero: three events on the first tick after the press
    set_limits(16'd0, 16'd0, 16'd0, 0);
    send_run(1'b0, 1);
    send_tick(1'b1);
    send_run(1'b0, 2);
    send_tick(1'b1);

    // thresholds out of order
    set_limits(16'd9, 16'd2, 16'd5, 0);
    send_run(1'b0, 12);
    send_tick(1'b1);

    // click only, then click released
    set_limits(16'd1, 16'hFFFF, 16'hFFFF, 1);
    send_run(1'b0, 3);
    send_tick(1'b1);

    // top thresholds: a press raises nothing
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_run(1'b0, 20);
    send_tick(1'b1);

    run_phase(0, 0, 110, 0);
    run_phase(77, 0, 110, 0);
    run_phase(0, 77, 110, 1);
    run_phase(33, 33, 110, 0);

    drain();
    stall_pct = 0;
    repeat (16) @(posedge clk);
    if (fail_count == 0 && events_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
